FILE: hdl/tnal_pkg.sv
// ============================================================================
// tnal_pkg
// Shared widths, codes and defaults of the timetable next-arrival lookup.
// ============================================================================
package tnal_pkg;

   // Default sizes of the route storage
   localparam int MAX_STATIONS_DEF = 32;
   localparam int MAX_TRIPS_DEF    = 64;

   // Field widths
   localparam int ID_W     = 16;
   localparam int TIME_W   = 17;
   localparam int CELL_W   = TIME_W + 1;   // {present, time}
   localparam int OP_W     = 2;
   localparam int SLOT_IN_W = 5;
   localparam int TRIP_IN_W = 6;
   localparam int STATUS_W = 2;

   // Configuration registers
   localparam int STATIONS_W = 6;
   localparam int TRIPS_W    = 7;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_STATIONS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIPS    = 1'b1;

   localparam logic [STATIONS_W-1:0] STATIONS_RESET = 6'd1;
   localparam logic [TRIPS_W-1:0]    TRIPS_RESET    = 7'd0;

   // Operation codes
   localparam logic [OP_W-1:0] OP_WR_STATION = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_CELL    = 2'd1;
   localparam logic [OP_W-1:0] OP_ARRIVAL    = 2'd2;
   localparam logic [OP_W-1:0] OP_ORDER      = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NONE    = 2'd1;
   localparam logic [STATUS_W-1:0] STS_MISSING = 2'd2;
   localparam logic [STATUS_W-1:0] STS_SAME    = 2'd3;

endpackage

FILE: hdl/tnal_ram.sv
// ============================================================================
// tnal_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module tnal_ram
   import tnal_pkg::*;
#(
   parameter int WIDTH = CELL_W,
   parameter int DEPTH = MAX_STATIONS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: hdl/timetable_next_arrival_lookup_core.sv
// ============================================================================
// timetable_next_arrival_lookup_core
// Route station list and station-by-trip timetable with arrival and order
// queries, served by a sequencer over two synchronous RAMs.
// ============================================================================
// Sequence: a write's result shows in the cycle after it is taken. A query
// scans the station slots up to the clamped stations_in_use, one slot a cycle
// on the station RAM read port; an arrival query then has the cell RAM's two
// read ports fetch one trip a cycle up to the clamped trips_in_use, ending at
// the first qualifying trip.
// Throughput: one item at a time; the next item is taken while a result shows.
// Reset: synchronous, clears control and config (stations 1, trips 0); RAM
// contents are undefined until written.
// ============================================================================
module timetable_next_arrival_lookup_core
   import tnal_pkg::*;
#(
   parameter int MAX_STATIONS = MAX_STATIONS_DEF,
   parameter int MAX_TRIPS    = MAX_TRIPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [SLOT_IN_W-1:0]  req_slot_index,
   input  logic [TRIP_IN_W-1:0]  req_trip_index,
   input  logic [ID_W-1:0]       req_first_station,
   input  logic [ID_W-1:0]       req_second_station,
   input  logic [TIME_W-1:0]     req_time_value,
   input  logic                  req_time_present,
   // result output
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [TIME_W-1:0]     rsp_arrival_time,
   output logic                  rsp_comes_before,
   // config write port
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int SLOT_W     = $clog2(MAX_STATIONS);
   localparam int CNT_S_W    = $clog2(MAX_STATIONS + 1);
   localparam int CNT_T_W    = $clog2(MAX_TRIPS + 1);
   localparam int CELL_DEPTH = MAX_STATIONS * MAX_TRIPS;
   localparam int CELL_AW    = $clog2(CELL_DEPTH);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FIND  = 2'd1;   // scan station slots
   localparam logic [1:0] ST_TRIPS = 2'd2;   // scan trip columns

   // ---------------------------------------------------------------- registers
   logic [1:0]            state_ff,  state_in;
   logic [OP_W-1:0]       op_ff,     op_in;
   logic [ID_W-1:0]       first_ff,  first_in;
   logic [ID_W-1:0]       second_ff, second_in;
   logic [TIME_W-1:0]     time_ff,   time_in;

   // station scan: issue counter plus read pipeline tag
   logic [CNT_S_W-1:0]    scnt_ff,     scnt_in;
   logic                  chk_vld_ff,  chk_vld_in;
   logic [SLOT_W-1:0]     chk_slot_ff, chk_slot_in;
   logic                  found_a_ff,  found_a_in;
   logic                  found_b_ff,  found_b_in;
   logic [SLOT_W-1:0]     pos_a_ff,    pos_a_in;
   logic [SLOT_W-1:0]     pos_b_ff,    pos_b_in;

   // trip scan: issue counter, cell addresses of both rows, read tag
   logic [CNT_T_W-1:0]    tcnt_ff,   tcnt_in;
   logic [CELL_AW-1:0]    addr_a_ff, addr_a_in;
   logic [CELL_AW-1:0]    addr_b_ff, addr_b_in;
   logic                  tv_ff,     tv_in;

   // result register
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [TIME_W-1:0]     rsp_arrival_ff, rsp_arrival_in;
   logic                  rsp_before_ff, rsp_before_in;

   // config registers
   logic [STATIONS_W-1:0] stations_in_use_ff, stations_in_use_in;
   logic [TRIPS_W-1:0]    trips_in_use_ff,    trips_in_use_in;

   // ---------------------------------------------------------------- memories
   logic                  accept;
   logic                  st_we;
   logic [SLOT_W-1:0]     st_waddr;
   logic [ID_W-1:0]       st_rdata;
   logic                  cell_we;
   logic [CELL_AW-1:0]    cell_waddr;
   logic [CELL_W-1:0]     cell_rdata_a;
   logic [CELL_W-1:0]     cell_rdata_b;
   logic [CNT_S_W-1:0]    n_st;
   logic [CNT_T_W-1:0]    n_tr;
   logic                  start_ok;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Out-of-range write targets are dropped, the item still gets its result.
   assign st_we    = accept && (req_op == OP_WR_STATION)
                     && (32'(req_slot_index) < MAX_STATIONS);
   assign st_waddr = SLOT_W'(req_slot_index);

   assign cell_we    = accept && (req_op == OP_WR_CELL)
                       && (32'(req_slot_index) < MAX_STATIONS)
                       && (32'(req_trip_index) < MAX_TRIPS);
   assign cell_waddr = CELL_AW'(32'(req_slot_index) * MAX_TRIPS + 32'(req_trip_index));

   // Writes only happen while idle and read data is only used while busy, so a
   // read that meets a write to the same entry in one cycle never feeds a result.
   tnal_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_STATIONS)
   ) u_station_ram (
      .clock     (clock),
      .wr_en     (st_we),
      .wr_addr   (st_waddr),
      .wr_data   (req_first_station),
      .rd_addr_a (scnt_ff[SLOT_W-1:0]),
      .rd_data_a (st_rdata),
      .rd_addr_b ('0),
      .rd_data_b ()
   );

   // port a follows the start-station row, port b the end-station row
   tnal_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_DEPTH)
   ) u_cell_ram (
      .clock     (clock),
      .wr_en     (cell_we),
      .wr_addr   (cell_waddr),
      .wr_data   ({req_time_present, req_time_value}),
      .rd_addr_a (addr_a_ff),
      .rd_data_a (cell_rdata_a),
      .rd_addr_b (addr_b_ff),
      .rd_data_b (cell_rdata_b)
   );

   // clamp the config counts to the storage size
   assign n_st = (32'(stations_in_use_ff) > MAX_STATIONS) ? CNT_S_W'(MAX_STATIONS)
                                                           : CNT_S_W'(stations_in_use_ff);
   assign n_tr = (32'(trips_in_use_ff) > MAX_TRIPS) ? CNT_T_W'(MAX_TRIPS)
                                                     : CNT_T_W'(trips_in_use_ff);

   // start cell qualifies: present with time at or after the query time
   assign start_ok = cell_rdata_a[TIME_W] && (cell_rdata_a[TIME_W-1:0] >= time_ff);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      time_in        = time_ff;
      scnt_in        = scnt_ff;
      chk_vld_in     = 1'b0;
      chk_slot_in    = chk_slot_ff;
      found_a_in     = found_a_ff;
      found_b_in     = found_b_ff;
      pos_a_in       = pos_a_ff;
      pos_b_in       = pos_b_ff;
      tcnt_in        = tcnt_ff;
      addr_a_in      = addr_a_ff;
      addr_b_in      = addr_b_ff;
      tv_in          = 1'b0;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_arrival_in = rsp_arrival_ff;
      rsp_before_in  = rsp_before_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = req_op;
               first_in   = req_first_station;
               second_in  = req_second_station;
               time_in    = req_time_value;
               scnt_in    = '0;
               found_a_in = 1'b0;
               found_b_in = 1'b0;
               tcnt_in    = '0;
               if (req_op == OP_WR_STATION || req_op == OP_WR_CELL) begin
                  // write done at this edge, report at once
                  rsp_strobe_in  = 1'b1;
                  rsp_status_in  = STS_OK;
                  rsp_arrival_in = '0;
                  rsp_before_in  = 1'b0;
               end else begin
                  state_in = ST_FIND;
               end
            end
         end

         ST_FIND: begin
            if (scnt_ff < n_st) begin
               scnt_in     = scnt_ff + 1'b1;
               chk_vld_in  = 1'b1;
               chk_slot_in = scnt_ff[SLOT_W-1:0];
            end
            // lowest matching slot wins
            if (chk_vld_ff) begin
               if (!found_a_ff && (st_rdata == first_ff)) begin
                  found_a_in = 1'b1;
                  pos_a_in   = chk_slot_ff;
               end
               if (!found_b_ff && (st_rdata == second_ff)) begin
                  found_b_in = 1'b1;
                  pos_b_in   = chk_slot_ff;
               end
            end
            if ((scnt_ff >= n_st) && !chk_vld_ff) begin
               rsp_arrival_in = '0;
               rsp_before_in  = 1'b0;
               if (!found_a_ff || !found_b_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STS_MISSING;
                  state_in      = ST_IDLE;
               end else if (op_ff == OP_ORDER) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
                  if (pos_a_ff == pos_b_ff) begin
                     rsp_status_in = STS_SAME;
                  end else begin
                     rsp_status_in = STS_OK;
                     rsp_before_in = (pos_a_ff < pos_b_ff);
                  end
               end else if (pos_a_ff > pos_b_ff) begin
                  // start after end on the route
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STS_NONE;
                  state_in      = ST_IDLE;
               end else begin
                  addr_a_in = CELL_AW'(32'(pos_a_ff) * MAX_TRIPS);
                  addr_b_in = CELL_AW'(32'(pos_b_ff) * MAX_TRIPS);
                  tcnt_in   = '0;
                  state_in  = ST_TRIPS;
               end
            end
         end

         ST_TRIPS: begin
            if (tcnt_ff < n_tr) begin
               tcnt_in   = tcnt_ff + 1'b1;
               addr_a_in = addr_a_ff + 1'b1;
               addr_b_in = addr_b_ff + 1'b1;
               tv_in     = 1'b1;
            end
            if (tv_ff && start_ok && cell_rdata_b[TIME_W]) begin
               // first qualifying trip, reads still in flight are dropped
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = STS_OK;
               rsp_arrival_in = cell_rdata_b[TIME_W-1:0];
               rsp_before_in  = 1'b0;
               tv_in          = 1'b0;
               state_in       = ST_IDLE;
            end else if ((tcnt_ff >= n_tr) && !tv_ff) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = STS_NONE;
               rsp_arrival_in = '0;
               rsp_before_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- config
   always_comb begin
      stations_in_use_in = stations_in_use_ff;
      trips_in_use_in    = trips_in_use_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STATIONS: stations_in_use_in = csr_write_data[STATIONS_W-1:0];
            CSR_TRIPS:    trips_in_use_in    = csr_write_data[TRIPS_W-1:0];
            default: begin
               stations_in_use_in = stations_in_use_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         chk_vld_ff         <= 1'b0;
         tv_ff              <= 1'b0;
         found_a_ff         <= 1'b0;
         found_b_ff         <= 1'b0;
         scnt_ff            <= '0;
         tcnt_ff            <= '0;
         rsp_strobe_ff      <= 1'b0;
         stations_in_use_ff <= STATIONS_RESET;
         trips_in_use_ff    <= TRIPS_RESET;
      end else begin
         state_ff           <= state_in;
         chk_vld_ff         <= chk_vld_in;
         tv_ff              <= tv_in;
         found_a_ff         <= found_a_in;
         found_b_ff         <= found_b_in;
         scnt_ff            <= scnt_in;
         tcnt_ff            <= tcnt_in;
         rsp_strobe_ff      <= rsp_strobe_in;
         stations_in_use_ff <= stations_in_use_in;
         trips_in_use_ff    <= trips_in_use_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      first_ff       <= first_in;
      second_ff      <= second_in;
      time_ff        <= time_in;
      chk_slot_ff    <= chk_slot_in;
      pos_a_ff       <= pos_a_in;
      pos_b_ff       <= pos_b_in;
      addr_a_ff      <= addr_a_in;
      addr_b_ff      <= addr_b_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_arrival_ff <= rsp_arrival_in;
      rsp_before_ff  <= rsp_before_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_arrival_time = rsp_arrival_ff;
   assign rsp_comes_before = rsp_before_ff;

   // ---------------------------------------------------------------- checks
   // a result always shows while the sequencer is back in idle
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while sequencer busy");

   // a query always starts the station scan
   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_ARRIVAL || req_op == OP_ORDER)) |=> busy)
      else $error("query accepted without starting scan");

   // trip scan only with both stations found, start not after end
   a_trip_scan_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIPS) |-> (found_a_ff && found_b_ff && (pos_a_ff <= pos_b_ff)))
      else $error("trip scan entered with bad station positions");

   // non-ok results carry zero payload
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STS_OK)) |-> (rsp_arrival_time == '0 && !rsp_comes_before))
      else $error("failed result carries nonzero payload");

endmodule
